[hw/rtl/tss_pkg.sv]
`timescale 1ns / 1ps

package tss_pkg;

    // Operation codes of a request
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_START_ACK = 2'd0;
    localparam logic [1:0] KIND_STOP_ACK  = 2'd1;
    localparam logic [1:0] KIND_EXPIRY    = 2'd2;
    localparam logic [1:0] KIND_WAIT      = 2'd3;

    // Offset that maps a signed difference onto an unsigned order
    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

    localparam logic [15:0] MAX_WAIT_RESET = 16'd60000;

    typedef struct packed {
        logic [1:0]  operation;
        logic [3:0]  timer_id;
        logic [31:0] delay;
        logic [31:0] repeat_period;
        logic [31:0] now_tick;
    } tss_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [3:0]  expired_id;
        logic        became_first;
        logic [15:0] wait_ticks;
        logic        last;
    } tss_res_t;

    // Running minimum of one scan
    typedef struct packed {
        logic        found;
        logic [31:0] key;
        logic [31:0] dl;
    } tss_best_t;

endpackage

[hw/rtl/tss_ram.sv]
`timescale 1ns / 1ps

module tss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/tss_scan.sv]
`timescale 1ns / 1ps

// Earliest-deadline tracker: takes one deadline per cycle from the RAM read port.
module tss_scan #(
    parameter int NUM_TIMERS = 16,
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clear,
    input  logic                   issue,
    input  logic [IDX_W-1:0]       issue_idx,
    input  logic [NUM_TIMERS-1:0]  armed,
    input  logic [31:0]            rdata,
    input  logic [31:0]            now,
    output tss_pkg::tss_best_t     best,
    output logic [IDX_W-1:0]       best_idx
);

    import tss_pkg::*;

    logic              p_valid_reg;
    logic [IDX_W-1:0]  p_idx_reg;
    tss_best_t         best_reg;
    tss_best_t         best_next;
    logic [IDX_W-1:0]  best_idx_reg;
    logic [IDX_W-1:0]  best_idx_next;
    logic [31:0]       key;

    assign key = (rdata - now) ^ SIGN_BIAS;

    always_comb
    begin
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        if (clear)
        begin
            best_next.found = 1'b0;
        end
        else if (p_valid_reg && armed[p_idx_reg] &&
                 (!best_reg.found || (key < best_reg.key)))
        begin
            // strict compare in ascending order keeps the lowest slot on ties
            best_next.found = 1'b1;
            best_next.key   = key;
            best_next.dl    = rdata;
            best_idx_next   = p_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg  <= 1'b0;
            p_idx_reg    <= '0;
            best_reg     <= '0;
            best_idx_reg <= '0;
        end
        else
        begin
            p_valid_reg  <= issue;
            p_idx_reg    <= issue_idx;
            best_reg     <= best_next;
            best_idx_reg <= best_idx_next;
        end
    end

    assign best     = best_reg;
    assign best_idx = best_idx_reg;

endmodule

[hw/rtl/timer_set_scheduler_top.sv]
`timescale 1ns / 1ps

// Timer slot scheduler. A request is taken when start is high and busy is low;
// every result it causes shows on result for one cycle with result_valid, and
// the one with result.last set ends the request. The receiver cannot stall, so
// results must be consumed as they appear. Stop, clear and an out-of-range
// start answer in the cycle after the request. A start in range runs one
// search for the earliest deadline, a tick one more after each expiry. Each
// search walks the deadline RAM through its single read port, one slot per
// cycle, then passes a drain state for the read latency and a decide state;
// after an expiry a reload state reads the period RAM and writes the new
// deadline back or disarms a one-shot slot. The user must write max_wait
// through cfg_we/cfg_wdata only while the block is idle; it is not enforced.
module timer_set_scheduler_top #(
    parameter int NUM_TIMERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  tss_pkg::tss_req_t request,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    output logic              result_valid,
    output tss_pkg::tss_res_t result
);

    import tss_pkg::*;

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_DECIDE = 5'b01000,
        ST_RELOAD = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [IDX_W-1:0]       scan_cnt_reg, scan_cnt_next;
    logic [NUM_TIMERS-1:0]  armed_reg, armed_next;
    logic [1:0]             op_reg, op_next;
    logic [3:0]             id_reg, id_next;
    logic [31:0]            now_reg, now_next;
    logic [15:0]            max_wait_reg;
    logic                   res_valid_reg, res_valid_next;
    tss_res_t               res_reg, res_next;

    // RAM ports
    logic                   dl_we;
    logic [IDX_W-1:0]       dl_waddr;
    logic [31:0]            dl_wdata;
    logic [31:0]            dl_rdata;
    logic                   per_we;
    logic [31:0]            per_rdata;

    // scan unit
    logic                   scan_clear;
    logic                   scan_issue;
    tss_best_t              best;
    logic [IDX_W-1:0]       best_idx;

    logic                   accept;
    logic                   in_range;
    logic [IDX_W-1:0]       req_idx;
    logic [31:0]            best_diff;
    logic                   best_expired;
    logic [31:0]            reload_diff;
    logic                   reload_behind;
    logic [15:0]            wait_val;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && (state_reg == ST_IDLE);
    assign in_range = (32'(request.timer_id) < 32'(NUM_TIMERS));
    assign req_idx  = IDX_W'(request.timer_id);

    // signed distance of the earliest deadline from now
    assign best_diff    = best.key ^ SIGN_BIAS;
    assign best_expired = best.found && (best.key <= SIGN_BIAS);

    // periodic reload: deadline falls behind when new distance is <= 0
    assign reload_diff   = best_diff + per_rdata;
    assign reload_behind = (reload_diff == 32'd0) || reload_diff[31];

    always_comb
    begin
        if (!best.found)
        begin
            wait_val = max_wait_reg;
        end
        else if (best_diff < {16'd0, max_wait_reg})
        begin
            wait_val = best_diff[15:0];
        end
        else
        begin
            wait_val = max_wait_reg;
        end
    end

    tss_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_deadline_ram (
        .clk   (clk),
        .we    (dl_we),
        .waddr (dl_waddr),
        .wdata (dl_wdata),
        .raddr (scan_cnt_reg),
        .rdata (dl_rdata)
    );

    tss_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS)) u_period_ram (
        .clk   (clk),
        .we    (per_we),
        .waddr (req_idx),
        .wdata (request.repeat_period),
        .raddr (best_idx),
        .rdata (per_rdata)
    );

    tss_scan #(.NUM_TIMERS(NUM_TIMERS)) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .issue     (scan_issue),
        .issue_idx (scan_cnt_reg),
        .armed     (armed_reg),
        .rdata     (dl_rdata),
        .now       (now_reg),
        .best      (best),
        .best_idx  (best_idx)
    );

    always_comb
    begin
        state_next     = state_reg;
        scan_cnt_next  = scan_cnt_reg;
        armed_next     = armed_reg;
        op_next        = op_reg;
        id_next        = id_reg;
        now_next       = now_reg;
        res_valid_next = 1'b0;
        res_next       = '0;
        dl_we          = 1'b0;
        dl_waddr       = req_idx;
        dl_wdata       = request.now_tick + request.delay;
        per_we         = 1'b0;
        scan_clear     = 1'b0;
        scan_issue     = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next  = request.operation;
                    id_next  = request.timer_id;
                    now_next = request.now_tick;
                    case (request.operation)
                        OP_START:
                        begin
                            if (in_range)
                            begin
                                dl_we               = 1'b1;
                                per_we              = 1'b1;
                                armed_next[req_idx] = 1'b1;
                                scan_clear          = 1'b1;
                                scan_cnt_next       = '0;
                                state_next          = ST_SCAN;
                            end
                            else
                            begin
                                // slot out of range: ack only
                                res_valid_next      = 1'b1;
                                res_next.kind       = KIND_START_ACK;
                                res_next.expired_id = request.timer_id;
                                res_next.last       = 1'b1;
                            end
                        end
                        OP_STOP:
                        begin
                            if (in_range)
                            begin
                                armed_next[req_idx] = 1'b0;
                            end
                            res_valid_next      = 1'b1;
                            res_next.kind       = KIND_STOP_ACK;
                            res_next.expired_id = request.timer_id;
                            res_next.last       = 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            armed_next     = '0;
                            res_valid_next = 1'b1;
                            res_next.kind  = KIND_STOP_ACK;
                            res_next.last  = 1'b1;
                        end
                        default:
                        begin
                            // tick
                            scan_clear    = 1'b1;
                            scan_cnt_next = '0;
                            state_next    = ST_SCAN;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                scan_issue = 1'b1;
                if (scan_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                res_valid_next = 1'b1;
                if (op_reg == OP_START)
                begin
                    res_next.kind         = KIND_START_ACK;
                    res_next.expired_id   = id_reg;
                    res_next.became_first = best.found && (best_idx == IDX_W'(id_reg));
                    res_next.last         = 1'b1;
                    state_next            = ST_IDLE;
                end
                else if (best_expired)
                begin
                    // period read of best_idx lands in the reload cycle
                    res_next.kind       = KIND_EXPIRY;
                    res_next.expired_id = 4'(best_idx);
                    state_next          = ST_RELOAD;
                end
                else
                begin
                    res_next.kind       = KIND_WAIT;
                    res_next.wait_ticks = wait_val;
                    res_next.last       = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            ST_RELOAD:
            begin
                if (per_rdata == 32'd0)
                begin
                    armed_next[best_idx] = 1'b0;
                end
                else
                begin
                    dl_we    = 1'b1;
                    dl_waddr = best_idx;
                    dl_wdata = reload_behind ? (now_reg + 32'd1) : (best.dl + per_rdata);
                end
                // rescan; the write lands before the first read of the new pass
                scan_clear    = 1'b1;
                scan_cnt_next = '0;
                state_next    = ST_SCAN;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            armed_reg     <= '0;
            max_wait_reg  <= MAX_WAIT_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_cnt_reg  <= scan_cnt_next;
            armed_reg     <= armed_next;
            res_valid_reg <= res_valid_next;
            if (cfg_we)
            begin
                max_wait_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        id_reg  <= id_next;
        now_reg <= now_next;
        res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // the final result of a request always leaves the block idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.last) |-> !busy)
        else $error("final result while busy");

    // intermediate results come only from a tick still in progress
    a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.last) |-> (busy && (result.kind == KIND_EXPIRY)))
        else $error("non-final result outside a tick");

    // an accepted request either goes busy or answers at once
    a_accept_resp: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || (result_valid && result.last)))
        else $error("request dropped");

endmodule

[test/tss_result_check.sv]
`timescale 1ns / 1ps

// Watches the request, config and result channels of the scheduler, keeps a
// shadow copy of the slot table and compares every result with the oldest
// predicted one.
module tss_result_check #(
    parameter int NUM_TIMERS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  tss_pkg::tss_req_t request,
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    input  logic              result_valid,
    input  tss_pkg::tss_res_t result,
    output int                fail_count,
    output int                pending,
    output int                expiries_seen
);
    import tss_pkg::*;

    logic        slot_armed    [NUM_TIMERS];
    logic [31:0] slot_deadline [NUM_TIMERS];
    logic [31:0] slot_period   [NUM_TIMERS];
    logic [15:0] wait_cap;

    tss_res_t    expected_results [$];
    tss_res_t    want;
    int          mismatches;
    int          expiries;

    // signed distance to now mapped onto an unsigned order
    function automatic logic [31:0] order_key(input logic [31:0] dl, input logic [31:0] now);
        return (dl - now) ^ SIGN_BIAS;
    endfunction

    // lowest (key, slot) among armed slots; -1 when nothing is armed
    function automatic int earliest_slot(input logic [31:0] now, output logic [31:0] key);
        int best;
        best = -1;
        key  = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            if (slot_armed[i] && (best < 0 || order_key(slot_deadline[i], now) < key))
            begin
                best = i;
                key  = order_key(slot_deadline[i], now);
            end
        end
        return best;
    endfunction

    function automatic tss_res_t make_result(input logic [1:0] kind, input logic [3:0] id,
                                             input logic first, input logic [15:0] wait_val,
                                             input logic last);
        tss_res_t r;
        r.kind         = kind;
        r.expired_id   = id;
        r.became_first = first;
        r.wait_ticks   = wait_val;
        r.last         = last;
        return r;
    endfunction

    task automatic predict_request(input tss_req_t r);
        logic [31:0] now;
        logic [31:0] key;
        logic [31:0] my_key;
        logic [31:0] diff;
        logic [15:0] wait_val;
        logic        first;
        logic        scanning;
        int          id;
        int          s;
        int          n;
        now = r.now_tick;
        id  = int'(r.timer_id);
        case (r.operation)
            OP_START:
            begin
                first = 1'b0;
                if (id < NUM_TIMERS)
                begin
                    slot_deadline[id] = now + r.delay;
                    slot_period[id]   = r.repeat_period;
                    slot_armed[id]    = 1'b1;
                    my_key = order_key(slot_deadline[id], now);
                    first  = 1'b1;
                    for (int i = 0; i < NUM_TIMERS; i++)
                    begin
                        if (slot_armed[i] && i != id)
                        begin
                            key = order_key(slot_deadline[i], now);
                            if (key < my_key || (key == my_key && i < id))
                                first = 1'b0;
                        end
                    end
                end
                expected_results.push_back(
                    make_result(KIND_START_ACK, r.timer_id, first, 16'd0, 1'b1));
            end
            OP_STOP:
            begin
                if (id < NUM_TIMERS)
                    slot_armed[id] = 1'b0;
                expected_results.push_back(
                    make_result(KIND_STOP_ACK, r.timer_id, 1'b0, 16'd0, 1'b1));
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < NUM_TIMERS; i++)
                    slot_armed[i] = 1'b0;
                expected_results.push_back(make_result(KIND_STOP_ACK, 4'd0, 1'b0, 16'd0, 1'b1));
            end
            default:
            begin
                // tick: pop expired slots earliest first, at most one pass per slot
                n = 0;
                scanning = 1'b1;
                while (scanning && n < NUM_TIMERS)
                begin
                    s = earliest_slot(now, key);
                    if (s < 0 || key > SIGN_BIAS)
                        scanning = 1'b0;
                    else
                    begin
                        expected_results.push_back(
                            make_result(KIND_EXPIRY, 4'(s), 1'b0, 16'd0, 1'b0));
                        if (slot_period[s] == '0)
                            slot_armed[s] = 1'b0;
                        else
                        begin
                            slot_deadline[s] = slot_deadline[s] + slot_period[s];
                            // reload that is still behind snaps to now + 1
                            if (order_key(slot_deadline[s], now) <= SIGN_BIAS)
                                slot_deadline[s] = now + 32'd1;
                        end
                        n++;
                    end
                end
                s = earliest_slot(now, key);
                if (s < 0 || key <= SIGN_BIAS)
                    wait_val = wait_cap;
                else
                begin
                    diff = key ^ SIGN_BIAS;
                    wait_val = (diff < 32'(wait_cap)) ? diff[15:0] : wait_cap;
                end
                expected_results.push_back(make_result(KIND_WAIT, 4'd0, 1'b0, wait_val, 1'b1));
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TIMERS; i++)
                slot_armed[i] = 1'b0;
            wait_cap = MAX_WAIT_RESET;
            expected_results.delete();
            mismatches = 0;
            expiries   = 0;
            fail_count    <= 0;
            pending       <= 0;
            expiries_seen <= 0;
        end
        else
        begin
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected kind=%0d id=%0d first=%0b wait=%0d last=%0b",
                                 $time, result.kind, result.expired_id, result.became_first,
                                 result.wait_ticks, result.last);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.kind !== want.kind || result.expired_id !== want.expired_id ||
                        result.became_first !== want.became_first ||
                        result.wait_ticks !== want.wait_ticks || result.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: expected kind=%0d id=%0d first=%0b wait=%0d last=%0b",
                                     $time, want.kind, want.expired_id, want.became_first,
                                     want.wait_ticks, want.last);
                            $display("%0t: got      kind=%0d id=%0d first=%0b wait=%0d last=%0b",
                                     $time, result.kind, result.expired_id,
                                     result.became_first, result.wait_ticks, result.last);
                        end
                    end
                end
                if (result.kind == KIND_EXPIRY)
                    expiries++;
            end
            if (cfg_we)
                wait_cap = cfg_wdata;
            if (start && !busy)
                predict_request(request);
            fail_count    <= mismatches;
            pending       <= expected_results.size();
            expiries_seen <= expiries;
        end
    end

endmodule

[test/timer_set_scheduler_top_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the timer slot scheduler. Prediction and comparison
// live in tss_result_check, which sits beside the block on the same wires.
module timer_set_scheduler_top_tb;
    import tss_pkg::*;

    localparam int NUM_TIMERS    = 16;
    // cycles with neither a request nor a result taken before giving up; a full
    // tick scans every slot between results, sender gaps are short
    localparam int IDLE_LIMIT    = 2000;
    // quiet time after the last result, a few scan lengths
    localparam int SETTLE_CYCLES = 3 * (NUM_TIMERS + 3);

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    tss_req_t    request;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        result_valid;
    tss_res_t    result;

    int          fail_count;
    int          pending;
    int          expiries_seen;
    int          idle_cycles;
    int          sent_per_op [4];
    int          settings_used;
    logic [31:0] now_count;     // free-running tick count the requests carry

    timer_set_scheduler_top #(
        .NUM_TIMERS(NUM_TIMERS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .result_valid(result_valid),
        .result      (result)
    );

    tss_result_check #(
        .NUM_TIMERS(NUM_TIMERS)
    ) result_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .result_valid (result_valid),
        .result       (result),
        .fail_count   (fail_count),
        .pending      (pending),
        .expiries_seen(expiries_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Watchdog: any accepted request or result restarts the count.
    initial idle_cycles = 0;
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic tss_req_t mk_req(input logic [1:0] op, input logic [3:0] id,
                                        input logic [31:0] dly, input logic [31:0] rep,
                                        input logic [31:0] now);
        tss_req_t r;
        r.operation     = op;
        r.timer_id      = id;
        r.delay         = dly;
        r.repeat_period = rep;
        r.now_tick      = now;
        return r;
    endfunction

    // Present a request and hold it until the block takes it. start stays high
    // afterwards so a back-to-back request needs no second assignment.
    task automatic send_request(input tss_req_t r);
        start   <= 1'b1;
        request <= r;
        do
            @(posedge clk);
        while (busy);
        sent_per_op[r.operation]++;
    endtask

    // Random sender gap, geometric length; pct is the idle chance per cycle.
    task automatic idle_sender(input int pct);
        while ($urandom_range(99) < pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
    endtask

    // Pause until every predicted result has arrived and the block is idle.
    task automatic drain_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0 || busy);
    endtask

    task automatic write_max_wait(input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly well-formed traffic on a slowly advancing clock: short delays so
    // slots actually expire, a mix of one-shot and periodic slots, and ticks
    // that step now forward a little. Full-width values and clock jumps come
    // in now and then, and unused fields carry noise.
    task automatic random_request(output tss_req_t r);
        int pick;
        int shape;
        pick            = $urandom_range(99);
        r.timer_id      = 4'($urandom_range(15));
        r.delay         = $urandom;
        r.repeat_period = $urandom;
        if (pick < 45)
        begin
            r.operation = OP_START;
            shape = $urandom_range(9);
            if (shape == 1)
                r.delay = '0;
            else if (shape > 1)
                r.delay = $urandom_range(60);
            shape = $urandom_range(9);
            if (shape < 4)
                r.repeat_period = '0;
            else if (shape > 4)
                r.repeat_period = $urandom_range(1, 40);
        end
        else if (pick < 85)
        begin
            r.operation = OP_TICK;
            shape = $urandom_range(19);
            if (shape == 0)
                now_count = $urandom;
            else if (shape > 1)
                now_count = now_count + $urandom_range(1, 20);
        end
        else if (pick < 97)
            r.operation = OP_STOP;
        else
            r.operation = OP_CLEAR;
        r.now_tick = now_count;
        // occasional start or stop seen from a far-off clock
        if (r.operation != OP_TICK && $urandom_range(19) == 0)
            r.now_tick = $urandom;
    endtask

    task automatic run_phase(input int items, input int idle_pct);
        tss_req_t r;
        for (int k = 0; k < items; k++)
        begin
            idle_sender(idle_pct);
            random_request(r);
            send_request(r);
            // now and then let the block run dry mid-phase
            if ($urandom_range(39) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        request       = '0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        settings_used = 0;
        now_count     = '0;
        for (int i = 0; i < 4; i++)
            sent_per_op[i] = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset max_wait.
        // tick with nothing armed reports the cap
        send_request(mk_req(OP_TICK, 4'd0, 32'd0, 32'd0, 32'd0));
        // stop of a slot that was never started
        send_request(mk_req(OP_STOP, 4'd5, 32'd0, 32'd0, 32'd0));
        // zero delay: due right now, first since nothing else is armed
        send_request(mk_req(OP_START, 4'd0, 32'd0, 32'd0, 32'd0));
        // all-ones fields: deadline wraps to one behind now, periodic reload falls behind
        send_request(mk_req(OP_START, 4'd15, '1, '1, '1));
        // same deadline as slot 0: the lower slot wins the tie, slot 15 is earlier still
        send_request(mk_req(OP_START, 4'd3, 32'd0, 32'd50, 32'd0));
        // expires slot 15 (reload snaps to now + 1), slot 0 one-shot, slot 3 periodic
        send_request(mk_req(OP_TICK, 4'd0, 32'd0, 32'd0, 32'd0));
        // half-range delay reads as a deadline in the past
        send_request(mk_req(OP_START, 4'd9, 32'h8000_0000, 32'd0, 32'd100));
        send_request(mk_req(OP_CLEAR, 4'd0, 32'd0, 32'd0, 32'd100));
        // every slot due at the same tick: sixteen expiries in slot order
        for (int i = 0; i < NUM_TIMERS; i++)
            send_request(mk_req(OP_START, 4'(i), 32'd10, 32'(i), 32'd5000));
        send_request(mk_req(OP_TICK, 4'd0, 32'd0, 32'd0, 32'd5010));
        drain_results();
        now_count = 32'd5010;

        // Random part: max_wait at the extremes and in between, with sender idle
        // rates of 0, 49, 35 and 0 percent.
        write_max_wait(16'd1);
        run_phase(61, 0);
        write_max_wait(16'd65535);
        run_phase(61, 49);
        write_max_wait(16'd0);
        run_phase(62, 35);
        write_max_wait(16'($urandom_range(1, 65535)));
        run_phase(61, 0);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d starts, %0d stops, %0d ticks and %0d clears under %0d max_wait values;",
                 sent_per_op[OP_START], sent_per_op[OP_STOP], sent_per_op[OP_TICK],
                 sent_per_op[OP_CLEAR], settings_used + 1);
        $display("%0d expiries were checked, %0d mismatches counted.", expiries_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/tss_pkg.sv
hw/rtl/tss_ram.sv
hw/rtl/tss_scan.sv
hw/rtl/timer_set_scheduler_top.sv
test/tss_result_check.sv
test/timer_set_scheduler_top_tb.sv
